// ===== rtl/core/stb_pkg.sv =====
package stb_pkg;

  // Bank geometry
  localparam int NumTimers  = 16;
  localparam int CountW     = 32;
  localparam int MaxResults = 16;

  localparam int IdxW     = (NumTimers > 1) ? $clog2(NumTimers) : 1;
  localparam int CntW     = $clog2(NumTimers + 1);
  localparam int FireIdxW = $clog2(MaxResults);
  localparam int FireCntW = $clog2(MaxResults + 1);

  // Operation codes
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } opcode_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_START_ERR = 2'd1,
    ST_STOP_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  timer_id;
    logic [30:0] initial_ms;
    logic [30:0] interval_ms;
    logic        oneshot;
    logic [23:0] elapsed_ms;
  } stb_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       fired;
    logic [3:0] fired_id;
    logic [4:0] active_count;
    logic       last;
  } stb_out_t;

  // Controller to datapath
  typedef struct packed {
    logic apply_op;
    logic tick_start;
    logic walk_step;
    logic emit_load;
  } stb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_last;
    logic emit_last;
  } stb_stat_t;

endpackage

// ===== rtl/core/software_timer_bank_core.sv =====
// Bank of one-shot / periodic countdown timers, one slot per timer id.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one command beat:
// start, stop or tick. Output channel (out_valid_o / out_ready_i /
// out_data_o) returns result beats; the final beat of a command has last set.
// Start, stop and unused codes: one result beat, valid on the cycle after the
// command beat is taken.
// Tick: the bank is walked one slot per cycle, all NumTimers slots, then one
// beat per expired slot in ascending id (at most 16), or a single beat with
// fired clear when nothing expired. Every beat of a tick carries the active
// count after the whole walk.
// One command is in flight at a time: a tick runs the command beat, the walk
// one slot at a time, then its result beats.
// A new command beat is taken while the last result beat is being taken.
// Result beats are held in an output register; while the receiver stalls
// the block simply holds and takes no new command.
// Reset clears every slot to disarmed, the active count to zero and the
// output channel to empty; the block is ready on the first cycle after.
module software_timer_bank_core import stb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  stb_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output stb_out_t out_data_o
);

  stb_cmd_t  cmd;
  stb_stat_t stat;

  stb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  stb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/stb_ctrl.sv =====
module stb_ctrl import stb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  stb_stat_t  stat_i,
  output stb_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Sequence one item: apply, or walk the bank then emit the fire list
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_free    = !out_valid_q || out_ready_i;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (in_opcode_i == OP_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = S_WALK;
          end else begin
            cmd_o.apply_op = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit_load = 1'b1;
          out_valid_d     = 1'b1;
          if (stat_i.emit_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/stb_datapath.sv =====
module stb_datapath import stb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  stb_cmd_t  cmd_i,
  input  stb_in_t   in_data_i,
  output stb_stat_t stat_o,
  output stb_out_t  out_data_o
);

  localparam int XW = CountW + 32;
  localparam logic signed [CountW-1:0] CountMax = {1'b0, {(CountW-1){1'b1}}};
  localparam logic signed [CountW-1:0] CountMin = {1'b1, {(CountW-1){1'b0}}};

  // Slot state
  logic [NumTimers-1:0]     armed_q;
  logic [NumTimers-1:0]     oneshot_q;
  logic signed [CountW-1:0] rem_q [NumTimers];
  logic [30:0]              ivl_q [NumTimers];
  logic [CntW-1:0]          cnt_q;

  // Tick bookkeeping
  logic [23:0]         elapsed_q;
  logic [IdxW-1:0]     walk_idx_q;
  logic [IdxW-1:0]     fire_ids_q [MaxResults];
  logic [FireCntW-1:0] fire_cnt_q;
  logic [FireCntW-1:0] emit_idx_q;
  stb_out_t            out_q;

  // Start / stop decode
  logic                     id_ok, start_ok, stop_ok;
  logic [IdxW-1:0]          aidx;
  logic [CntW-1:0]          cnt_op;
  logic [1:0]               op_status;
  logic signed [XW-1:0]     init_ext, max_ext, min_ext;
  logic signed [CountW-1:0] init_sat;

  // Walk arithmetic
  logic [IdxW-1:0]          widx;
  logic signed [CountW-1:0] r_cur, r_sub, r_new;
  logic signed [XW-1:0]     r_ext, el_ext, diff, sub_ext, ivl_ext, sum;
  logic                     fire_now, push;

  assign max_ext = {{(XW-CountW){1'b0}}, CountMax};
  assign min_ext = {{(XW-CountW){1'b1}}, CountMin};

  // Decode start and stop against the addressed slot
  always_comb begin
    id_ok    = int'(in_data_i.timer_id) < NumTimers;
    aidx     = IdxW'(in_data_i.timer_id);
    start_ok = (in_data_i.opcode == OP_START) && id_ok && !armed_q[aidx];
    stop_ok  = (in_data_i.opcode == OP_STOP) && id_ok && armed_q[aidx];
    cnt_op   = cnt_q;
    if (start_ok) begin
      cnt_op = cnt_q + CntW'(1);
    end else if (stop_ok) begin
      cnt_op = cnt_q - CntW'(1);
    end
    op_status = ST_OK;
    if (in_data_i.opcode == OP_START && !start_ok) begin
      op_status = ST_START_ERR;
    end else if (in_data_i.opcode == OP_STOP && !stop_ok) begin
      op_status = ST_STOP_ERR;
    end
    init_ext = XW'(in_data_i.initial_ms);
    init_sat = (init_ext > max_ext) ? CountMax : init_ext[CountW-1:0];
  end

  // Subtract elapsed time, saturate low, reload on expiry and saturate high
  always_comb begin
    widx    = walk_idx_q;
    r_cur   = rem_q[widx];
    r_ext   = {{(XW-CountW){r_cur[CountW-1]}}, r_cur};
    el_ext  = XW'(elapsed_q);
    diff    = r_ext - el_ext;
    r_sub   = (diff < min_ext) ? CountMin : diff[CountW-1:0];
    sub_ext = {{(XW-CountW){r_sub[CountW-1]}}, r_sub};
    ivl_ext = XW'(ivl_q[widx]);
    sum     = sub_ext + ivl_ext;
    r_new   = r_sub;
    if (r_sub[CountW-1]) begin
      r_new = (sum > max_ext) ? CountMax : sum[CountW-1:0];
    end
    fire_now = cmd_i.walk_step && armed_q[widx] && r_sub[CountW-1];
    push     = fire_now && (int'(fire_cnt_q) < MaxResults);
  end

  assign stat_o.walk_last = (int'(walk_idx_q) == NumTimers - 1);
  assign stat_o.emit_last = (fire_cnt_q == '0) ||
                            (emit_idx_q == fire_cnt_q - FireCntW'(1));

  function automatic logic [4:0] sat_count(input logic [CntW-1:0] c);
    sat_count = (int'(c) > 31) ? 5'd31 : 5'(c);
  endfunction

  // Control state: armed bits, active count and walk counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= '0;
      cnt_q      <= '0;
      walk_idx_q <= '0;
      fire_cnt_q <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.apply_op) begin
        if (start_ok) armed_q[aidx] <= 1'b1;
        if (stop_ok) armed_q[aidx] <= 1'b0;
        cnt_q <= cnt_op;
      end
      if (fire_now && oneshot_q[widx]) begin
        armed_q[widx] <= 1'b0;
        cnt_q         <= cnt_q - CntW'(1);
      end
      if (cmd_i.tick_start) begin
        walk_idx_q <= '0;
        fire_cnt_q <= '0;
        emit_idx_q <= '0;
      end else begin
        if (cmd_i.walk_step) walk_idx_q <= walk_idx_q + IdxW'(1);
        if (push) fire_cnt_q <= fire_cnt_q + FireCntW'(1);
        if (cmd_i.emit_load) emit_idx_q <= emit_idx_q + FireCntW'(1);
      end
    end
  end

  // Slot payload, fire list and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      elapsed_q <= in_data_i.elapsed_ms;
    end
    if (cmd_i.apply_op && start_ok) begin
      rem_q[aidx]     <= init_sat;
      ivl_q[aidx]     <= in_data_i.interval_ms;
      oneshot_q[aidx] <= in_data_i.oneshot;
    end
    if (cmd_i.walk_step && armed_q[widx]) begin
      rem_q[widx] <= r_new;
    end
    if (push) begin
      fire_ids_q[fire_cnt_q[FireIdxW-1:0]] <= widx;
    end
    if (cmd_i.apply_op) begin
      out_q.status       <= op_status;
      out_q.fired        <= 1'b0;
      out_q.fired_id     <= '0;
      out_q.active_count <= sat_count(cnt_op);
      out_q.last         <= 1'b1;
    end else if (cmd_i.emit_load) begin
      out_q.status       <= ST_OK;
      out_q.fired        <= (fire_cnt_q != '0);
      out_q.fired_id     <= (fire_cnt_q != '0) ?
                            4'(fire_ids_q[emit_idx_q[FireIdxW-1:0]]) : 4'd0;
      out_q.active_count <= sat_count(cnt_q);
      out_q.last         <= stat_o.emit_last;
    end
  end

  assign out_data_o = out_q;

endmodule
